// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the list RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define IIEL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define IIEL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the next cycle
`define IIEL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/iiel_pkg.sv =====
// Types and codes shared by the indexed insert/erase list
`default_nettype none

package iiel_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_ERASE  = 2'd2,
    CMD_GET    = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [6:0]         position;
    logic signed [31:0] item_value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    status_t            status;
    logic [6:0]         entry_count;
  } out_rsp_t;

  typedef struct packed {
    logic app;
    logic ins;
    logic ers;
  } shift_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/indexed_insert_erase_list.sv =====
// Top level of the indexed insert/erase list
// The list takes one request per clock cycle while in_stall is low and registers its
// result in the output buffer for out_req; a row of CAPACITY cells updates every
// entry at once, so an insert or erase anywhere in the list is as quick as an append
// or a get. Results pass through a two-deep output buffer, so in_stall rises only
// after two results are waiting. Entries are not cleared at reset; only the entry
// count is. Every result carries the status (ok, index out of range, list full) and
// the count after the request.
`default_nettype none
`include "assert_macros.svh"

module indexed_insert_erase_list
  import iiel_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_req_t  in_req,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_rsp_t      out_req
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               acc;
  logic               buf_full;
  logic               full;
  logic [CMP_W-1:0]   pos_x;
  logic [CMP_W-1:0]   cnt_x;
  logic               bad_ins;
  logic               bad_idx;
  logic signed [31:0] rd_sel;
  logic signed [31:0] ent [CAPACITY];
  shift_ctl_t         ctl;
  out_rsp_t           rsp;

  assign acc      = in_valid && !buf_full;
  assign in_stall = buf_full;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign pos_x    = CMP_W'(in_req.position);
  assign cnt_x    = CMP_W'(count_r);
  assign bad_ins  = pos_x > cnt_x;
  assign bad_idx  = pos_x >= cnt_x;

  always_comb begin
    rd_sel = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (pos_x == CMP_W'(k)) begin
        rd_sel = ent[k];
      end
    end
  end

  always_comb begin
    ctl             = '0;
    rsp.read_value  = '0;
    rsp.status      = ST_OK;
    case (in_req.cmd)
      CMD_APPEND: begin
        if (full) begin
          rsp.status = ST_FULL;
        end else begin
          ctl.app = acc;
        end
      end
      CMD_INSERT: begin
        if (bad_ins) begin
          rsp.status = ST_RANGE;
        end else if (full) begin
          rsp.status = ST_FULL;
        end else begin
          ctl.ins = acc;
        end
      end
      CMD_ERASE: begin
        if (bad_idx) begin
          rsp.status = ST_RANGE;
        end else begin
          ctl.ers = acc;
        end
      end
      CMD_GET: begin
        if (bad_idx) begin
          rsp.status = ST_RANGE;
        end else begin
          rsp.read_value = rd_sel;
        end
      end
      default: begin
        rsp.status = ST_OK;
      end
    endcase
    count_nxt = count_r;
    if (ctl.app || ctl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.ers) begin
      count_nxt = count_r - CNT_W'(1);
    end
    rsp.entry_count = 7'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_ent;
    logic signed [31:0] right_ent;

    if (i == 0) begin : g_first
      assign left_ent = '0;
    end else begin : g_mid_l
      assign left_ent = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_mid_r
      assign right_ent = ent[i+1];
    end

    iiel_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (pos_x[CNT_W-1:0]),
      .cnt       (count_r),
      .val       (in_req.item_value),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .entry     (ent[i])
    );
  end

  iiel_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .push_rsp  (rsp),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_req)
  );

  `IIEL_ASSERT(a_count_bound, count_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `IIEL_ASSERT_NXT(a_idle_count_kept, !acc, $stable(count_r), "count moved without a request")
  `IIEL_ASSERT_IMP(a_one_shift_op, 1'b1, $onehot0({ctl.app, ctl.ins, ctl.ers}),
                   "more than one shift operation at once")

endmodule

`default_nettype wire

// ===== rtl/iiel_cell.sv =====
// One storage cell of the list row: holds one entry and shifts with its neighbors
`default_nettype none

module iiel_cell
  import iiel_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  wire logic                    clk,
  input  wire shift_ctl_t              ctl,
  input  wire logic [CNT_W-1:0]        pos,
  input  wire logic [CNT_W-1:0]        cnt,
  input  wire logic signed [31:0]      val,
  input  wire logic signed [31:0]      left_ent,
  input  wire logic signed [31:0]      right_ent,
  output logic signed [31:0]           entry
);

  localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

  logic signed [31:0] entry_r;
  logic signed [31:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.app && (MY_IDX == cnt)) begin
      entry_nxt = val;
    end else if (ctl.ins) begin
      if (MY_IDX == pos) begin
        entry_nxt = val;
      end else if ((MY_IDX > pos) && (MY_IDX <= cnt)) begin
        entry_nxt = left_ent;
      end
    end else if (ctl.ers && (MY_IDX >= pos) && (MY_NEXT < cnt)) begin
      entry_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

// ===== rtl/iiel_out_buf.sv =====
// Two-deep result buffer: output register plus skid register
`default_nettype none
`include "assert_macros.svh"

module iiel_out_buf
  import iiel_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire out_rsp_t push_rsp,
  output logic          full,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_rsp_t      out_rsp
);

  logic     out_vld_r;
  logic     out_vld_nxt;
  out_rsp_t out_r;
  out_rsp_t out_nxt;
  logic     skid_vld_r;
  logic     skid_vld_nxt;
  out_rsp_t skid_r;
  out_rsp_t skid_nxt;
  logic     drain;

  assign drain = !out_vld_r || !out_stall;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (drain) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = push;
        out_nxt     = push_rsp;
      end
    end else if (push) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = push_rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_rsp   = out_r;

  `IIEL_ASSERT_IMP(a_skid_behind_out, skid_vld_r, out_vld_r, "skid holds a request ahead of output")
  `IIEL_ASSERT_NXT(a_stalled_out_kept, out_vld_r && out_stall, out_vld_r, "stalled result dropped")
  `IIEL_ASSERT_IMP(a_no_push_when_full, skid_vld_r, !push, "request pushed into full buffer")

endmodule

`default_nettype wire
